// ===== src/sgc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgc_pkg
// shared types and constants of the slab geometry calculator
// ----------------------------------------------------------------------------
package sgc_pkg;

   // field widths
   localparam int SIZE_W      = 17;
   localparam int ALIGN_W     = 4;
   localparam int LIMIT_W     = 7;
   localparam int PAGES_OUT_W = 5;
   localparam int OBJS_W      = 14;
   localparam int WASTE_W     = 7;

   // request clamps
   localparam int SIZE_CAP  = 65536;
   localparam int ALIGN_CAP = 12;

   // waste percent arithmetic, in parts per million
   localparam int PPM      = 1000000;
   localparam int PPM_W    = 20;
   localparam int VAL_W    = 20;
   localparam int PCT_DIV  = 10000;
   localparam int PCT_HALF = 5000;

   // whole percent from parts per million: x / 10000 is (x >> 4) * 107375 >> 26 for x < 2^20
   localparam int                     PCT_PRE     = 4;
   localparam int                     PCT_RECIP_W = 17;
   localparam logic [PCT_RECIP_W-1:0] PCT_RECIP   = 17'd107375;
   localparam int                     PCT_SHIFT   = 26;
   localparam int                     PCT_PROD_W  = VAL_W - PCT_PRE + PCT_RECIP_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd10;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GROW,
      ST_D1_GO,
      ST_D1_WAIT,
      ST_MUL,
      ST_D2_GO,
      ST_D2_WAIT,
      ST_ROUND,
      ST_CHECK,
      ST_DONE
   } state_type;

   // which division the shared divider runs
   typedef enum logic [1:0] {
      DSEL_SLAB_BY_OBJ,
      DSEL_SCALED_BY_SLAB
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        grow;
      logic        div_go;
      logic        cap;
      logic        mul;
      logic        round;
      div_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic slab_lt_obj;
      logic div_done;
      logic grow_ok;
   } status_type;

endpackage
`default_nettype wire

// ===== src/slab_geometry_calculator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slab_geometry_calculator_top
// slab sizing for one object size and alignment per request
// ----------------------------------------------------------------------------
// a word is accepted when start is high while busy is low; busy then stays
// high until the result has been shown. the result is on the rsp_ ports for
// exactly one cycle, marked by rsp_valid, and cannot be held off, so the
// receiver must take it in that cycle. between 1 and MAX_SLAB_PAGES page
// counts are tried, from the fewest pages that hold one object upward. per
// page count the shared 37-bit one-bit-per-cycle divider first runs slab /
// object; the remainder is then scaled to parts per million, and the divider
// runs scaled remainder / slab; last, the parts per million are split into
// whole percent by reciprocal multiply and the limit is checked. the waste
// limit register may be written any time the block is idle and takes effect
// on the next word; it resets to 10 percent.
// ----------------------------------------------------------------------------
module slab_geometry_calculator_top #(
   parameter int PAGE_BYTES     = 4096,
   parameter int MAX_SLAB_PAGES = 16,
   parameter int MIN_ALIGN_LOG2 = 3
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request word
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [sgc_pkg::SIZE_W-1:0]          req_size_bytes,
   input  wire logic [sgc_pkg::ALIGN_W-1:0]         req_align_log2,
   // result word
   output logic                                     rsp_valid,
   output logic [sgc_pkg::SIZE_W-1:0]               rsp_object_bytes,
   output logic [sgc_pkg::PAGES_OUT_W-1:0]          rsp_slab_pages,
   output logic [sgc_pkg::OBJS_W-1:0]               rsp_objects_per_slab,
   output logic [sgc_pkg::WASTE_W-1:0]              rsp_waste_percent,
   // waste limit register
   input  wire logic                                csr_wr_en,
   input  wire logic [sgc_pkg::LIMIT_W-1:0]         csr_wr_data
);

   // page count can reach the first fit of the largest object or the cap
   localparam int FIRST_MAX = (sgc_pkg::SIZE_CAP + PAGE_BYTES - 1) / PAGE_BYTES;
   localparam int PG_MAX    = (FIRST_MAX > MAX_SLAB_PAGES) ? FIRST_MAX : MAX_SLAB_PAGES;
   localparam int PG_W      = $clog2(PG_MAX + 1);
   localparam int SLAB_W    = $clog2(PG_MAX * PAGE_BYTES + 1);
   // remainder times one million is the widest dividend
   localparam int PROD_W    = sgc_pkg::SIZE_W + sgc_pkg::PPM_W;
   localparam int DIV_W     = (SLAB_W > PROD_W) ? SLAB_W : PROD_W;

   sgc_pkg::cmd_type    cmd;
   sgc_pkg::status_type status;

   // sequencer: page search loop and division order
   sgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath with the shared divider and result registers
   sgc_dp #(
      .PAGE_BYTES     (PAGE_BYTES),
      .MAX_SLAB_PAGES (MAX_SLAB_PAGES),
      .MIN_ALIGN_LOG2 (MIN_ALIGN_LOG2),
      .PG_W           (PG_W),
      .SLAB_W         (SLAB_W),
      .DIV_W          (DIV_W)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_size_bytes       (req_size_bytes),
      .req_align_log2       (req_align_log2),
      .rsp_object_bytes     (rsp_object_bytes),
      .rsp_slab_pages       (rsp_slab_pages),
      .rsp_objects_per_slab (rsp_objects_per_slab),
      .rsp_waste_percent    (rsp_waste_percent)
   );

   // an accepted word keeps the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted word");

   // a result only follows a word in flight
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a word in flight");

   // one strobe per word, and the block is free right after it
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   // rounded waste never exceeds the whole slab
   a_waste_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_waste_percent <= 7'd100))
      else $error("waste percent out of range");

endmodule
`default_nettype wire

// ===== src/sgc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgc_div
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sgc_div #(
   parameter int W = 37
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         go,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quot,
   output logic [W-1:0]      rem
);

   localparam int CNT_W = $clog2(W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     quot_ff, quot_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [W:0]       trial;

   always_comb begin
      trial   = {rem_ff, quot_ff[W-1]} - {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (go) begin
         run_in  = 1'b1;
         cnt_in  = CNT_W'(W);
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (run_ff) begin
         if (!trial[W]) begin
            rem_in  = trial[W-1:0];
            quot_in = {quot_ff[W-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[W-2:0], quot_ff[W-1]};
            quot_in = {quot_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// ===== src/sgc_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgc_dp
// datapath: request clamp, slab size, waste arithmetic and result registers
// ----------------------------------------------------------------------------
module sgc_dp #(
   parameter int PAGE_BYTES     = 4096,
   parameter int MAX_SLAB_PAGES = 16,
   parameter int MIN_ALIGN_LOG2 = 3,
   parameter int PG_W           = 5,
   parameter int SLAB_W         = 17,
   parameter int DIV_W          = 37
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sgc_pkg::cmd_type                    cmd,
   output sgc_pkg::status_type                      status,
   input  wire logic                                csr_wr_en,
   input  wire logic [sgc_pkg::LIMIT_W-1:0]         csr_wr_data,
   input  wire logic [sgc_pkg::SIZE_W-1:0]          req_size_bytes,
   input  wire logic [sgc_pkg::ALIGN_W-1:0]         req_align_log2,
   output logic [sgc_pkg::SIZE_W-1:0]               rsp_object_bytes,
   output logic [sgc_pkg::PAGES_OUT_W-1:0]          rsp_slab_pages,
   output logic [sgc_pkg::OBJS_W-1:0]               rsp_objects_per_slab,
   output logic [sgc_pkg::WASTE_W-1:0]              rsp_waste_percent
);

   logic [sgc_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [sgc_pkg::SIZE_W-1:0]  obj_ff, obj_in;
   logic [SLAB_W-1:0]           slab_ff, slab_in;
   logic [PG_W-1:0]             pages_ff, pages_in;
   logic [SLAB_W-1:0]           q1_ff, q1_in;
   logic [sgc_pkg::SIZE_W-1:0]  rem1_ff, rem1_in;
   logic [DIV_W-1:0]            prod_ff, prod_in;
   logic [sgc_pkg::VAL_W-1:0]   val_ff, val_in;
   logic [sgc_pkg::WASTE_W-1:0] waste_ff, waste_in;

   logic [sgc_pkg::SIZE_W-1:0]     size_c;
   logic [sgc_pkg::ALIGN_W-1:0]    lg_c;
   logic [sgc_pkg::SIZE_W-1:0]     mask_c;
   logic [DIV_W-1:0]               div_a, div_b, div_q, div_r;
   logic                           div_done;
   logic [sgc_pkg::PCT_PROD_W-1:0] pct_prod;

   // request clamp and alignment round-up
   always_comb begin
      size_c = req_size_bytes;
      if (size_c == '0)
         size_c = sgc_pkg::SIZE_W'(1);
      if (size_c > sgc_pkg::SIZE_W'(sgc_pkg::SIZE_CAP))
         size_c = sgc_pkg::SIZE_W'(sgc_pkg::SIZE_CAP);
      lg_c = req_align_log2;
      if (lg_c > sgc_pkg::ALIGN_W'(sgc_pkg::ALIGN_CAP))
         lg_c = sgc_pkg::ALIGN_W'(sgc_pkg::ALIGN_CAP);
      if (lg_c < sgc_pkg::ALIGN_W'(MIN_ALIGN_LOG2))
         lg_c = sgc_pkg::ALIGN_W'(MIN_ALIGN_LOG2);
      mask_c = ~((sgc_pkg::SIZE_W'(1) << lg_c) - sgc_pkg::SIZE_W'(1));
   end

   // divider operand select
   always_comb begin
      case (cmd.sel)
         sgc_pkg::DSEL_SLAB_BY_OBJ: begin
            div_a = DIV_W'(slab_ff);
            div_b = DIV_W'(obj_ff);
         end
         sgc_pkg::DSEL_SCALED_BY_SLAB: begin
            div_a = prod_ff;
            div_b = DIV_W'(slab_ff);
         end
         default: begin
            div_a = DIV_W'(slab_ff);
            div_b = DIV_W'(obj_ff);
         end
      endcase
   end

   sgc_div #(
      .W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   // whole percent of the biased parts per million by reciprocal multiplication
   always_comb begin
      pct_prod = sgc_pkg::PCT_PROD_W'(val_ff[sgc_pkg::VAL_W-1:sgc_pkg::PCT_PRE])
               * sgc_pkg::PCT_PROD_W'(sgc_pkg::PCT_RECIP);
   end

   always_comb begin
      limit_in = limit_ff;
      obj_in   = obj_ff;
      slab_in  = slab_ff;
      pages_in = pages_ff;
      q1_in    = q1_ff;
      rem1_in  = rem1_ff;
      prod_in  = prod_ff;
      val_in   = val_ff;
      waste_in = waste_ff;
      if (csr_wr_en)
         limit_in = csr_wr_data;
      if (cmd.load) begin
         obj_in   = (size_c + ~mask_c) & mask_c;
         slab_in  = SLAB_W'(PAGE_BYTES);
         pages_in = PG_W'(1);
      end
      if (cmd.grow) begin
         slab_in  = slab_ff + SLAB_W'(PAGE_BYTES);
         pages_in = pages_ff + PG_W'(1);
      end
      if (cmd.mul)
         prod_in = DIV_W'(rem1_ff) * DIV_W'(sgc_pkg::PPM);
      if (cmd.cap && div_done) begin
         case (cmd.sel)
            sgc_pkg::DSEL_SLAB_BY_OBJ: begin
               q1_in   = div_q[SLAB_W-1:0];
               rem1_in = div_r[sgc_pkg::SIZE_W-1:0];
            end
            sgc_pkg::DSEL_SCALED_BY_SLAB: begin
               // biased by half a percent so the split rounds half up
               val_in = div_q[sgc_pkg::VAL_W-1:0]
                      + sgc_pkg::VAL_W'(sgc_pkg::PCT_HALF);
            end
            default: begin
               waste_in = waste_ff;
            end
         endcase
      end
      if (cmd.round)
         waste_in = pct_prod[sgc_pkg::PCT_SHIFT +: sgc_pkg::WASTE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= sgc_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
      obj_ff   <= obj_in;
      slab_ff  <= slab_in;
      pages_ff <= pages_in;
      q1_ff    <= q1_in;
      rem1_ff  <= rem1_in;
      prod_ff  <= prod_in;
      val_ff   <= val_in;
      waste_ff <= waste_in;
   end

   always_comb begin
      status.slab_lt_obj = DIV_W'(slab_ff) < DIV_W'(obj_ff);
      status.div_done    = div_done;
      status.grow_ok     = (waste_ff > limit_ff) && (pages_ff < PG_W'(MAX_SLAB_PAGES));
   end

   assign rsp_object_bytes     = obj_ff;
   assign rsp_slab_pages       = sgc_pkg::PAGES_OUT_W'(pages_ff);
   assign rsp_objects_per_slab = sgc_pkg::OBJS_W'(q1_ff);
   assign rsp_waste_percent    = waste_ff;

endmodule
`default_nettype wire

// ===== src/sgc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgc_ctrl
// sequencer for page search and the two divisions of each page count
// ----------------------------------------------------------------------------
module sgc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output logic                      rsp_valid,
   output sgc_pkg::cmd_type          cmd,
   input  wire sgc_pkg::status_type  status
);

   sgc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.grow   = 1'b0;
      cmd.div_go = 1'b0;
      cmd.cap    = 1'b0;
      cmd.mul    = 1'b0;
      cmd.round  = 1'b0;
      cmd.sel    = sgc_pkg::DSEL_SLAB_BY_OBJ;
      busy       = (state_ff != sgc_pkg::ST_IDLE);
      rsp_valid  = (state_ff == sgc_pkg::ST_DONE);
      case (state_ff)
         sgc_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = sgc_pkg::ST_GROW;
            end
         end
         sgc_pkg::ST_GROW: begin
            // fewest pages that hold one object
            if (status.slab_lt_obj)
               cmd.grow = 1'b1;
            else
               state_in = sgc_pkg::ST_D1_GO;
         end
         sgc_pkg::ST_D1_GO: begin
            cmd.div_go = 1'b1;
            state_in   = sgc_pkg::ST_D1_WAIT;
         end
         sgc_pkg::ST_D1_WAIT: begin
            cmd.cap = 1'b1;
            if (status.div_done)
               state_in = sgc_pkg::ST_MUL;
         end
         sgc_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = sgc_pkg::ST_D2_GO;
         end
         sgc_pkg::ST_D2_GO: begin
            cmd.sel    = sgc_pkg::DSEL_SCALED_BY_SLAB;
            cmd.div_go = 1'b1;
            state_in   = sgc_pkg::ST_D2_WAIT;
         end
         sgc_pkg::ST_D2_WAIT: begin
            cmd.sel = sgc_pkg::DSEL_SCALED_BY_SLAB;
            cmd.cap = 1'b1;
            if (status.div_done)
               state_in = sgc_pkg::ST_ROUND;
         end
         sgc_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = sgc_pkg::ST_CHECK;
         end
         sgc_pkg::ST_CHECK: begin
            if (status.grow_ok) begin
               cmd.grow = 1'b1;
               state_in = sgc_pkg::ST_D1_GO;
            end else begin
               state_in = sgc_pkg::ST_DONE;
            end
         end
         sgc_pkg::ST_DONE: begin
            state_in = sgc_pkg::ST_IDLE;
         end
         default: begin
            state_in = sgc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire
